/* sv/ffpa_pkg.sv */
// ffpa_pkg: shared field widths, stream packing widths and action codes
// for the first-fit partition allocator; no dependencies
package ffpa_pkg;

    localparam int ACTION_W   = 2;
    localparam int INDEX_W    = 4;
    localparam int VALUE_W    = 16;
    localparam int PID_W      = 8;

    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;

    localparam int S_IDX_LSB  = 0;
    localparam int S_SIZE_LSB = S_IDX_LSB + INDEX_W;
    localparam int S_PID_LSB  = S_SIZE_LSB + VALUE_W;
    localparam int S_USED_W   = S_PID_LSB + PID_W;

    localparam int M_USED_W   = INDEX_W + 2 * VALUE_W + PID_W + 1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_ALLOC = 2'd1,
        ACT_FREE  = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

endpackage

/* sv/ffpa_table.sv */
// ffpa_table: partition table memory with one write port, one registered read port
// and per-entry valid bits so unwritten entries read back with rd_valid low; no dependencies
module ffpa_table #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 41
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data,
    output logic                                   rd_valid,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem_reg[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

/* sv/ffpa_fit.sv */
// ffpa_fit: shared compare and subtract unit that tests one partition against a request
// and gives the space left over; no dependencies
module ffpa_fit #(
    parameter int SIZE_BITS = 16
) (
    input  logic [SIZE_BITS-1:0] part_size,
    input  logic [SIZE_BITS-1:0] request,
    input  logic                 busy,
    output logic                 fits,
    output logic [SIZE_BITS-1:0] remain
);
    logic [SIZE_BITS:0] diff;

    assign diff   = {1'b0, part_size} - {1'b0, request};
    assign fits   = !busy && !diff[SIZE_BITS];
    assign remain = diff[SIZE_BITS-1:0];

endmodule

/* sv/first_fit_partition_allocator.sv */
// first_fit_partition_allocator: allocate scans 1 to NUM_PARTITIONS partitions from index 0,
// one per cycle through the shared fit unit and the single table read port, up to the first
// fit; the last step holds while the output is full. Load, free and read test one entry.
// a transaction is taken only in idle; idle takes a new transaction even while a result waits
// reset (aresetn low, synchronous) clears the sequencer, the output valid and all table
// valid bits, so every partition reads as size 0, free, leftover 0, owner 0
module first_fit_partition_allocator #(
    parameter int NUM_PARTITIONS = 16,
    parameter int SIZE_BITS      = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // block_index, size_value, process_id, zero fill
    input  logic [ffpa_pkg::S_TDATA_W-1:0]  s_tdata,
    // action
    input  logic [ffpa_pkg::ACTION_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // result_index, partition_size, leftover, owner_id, owner_valid, zero fill
    output logic [ffpa_pkg::M_TDATA_W-1:0]  m_tdata,
    // ok
    output logic                            m_tuser
);
    import ffpa_pkg::*;

    localparam int IW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
    localparam int EW = 2 * SIZE_BITS + PID_W + 1;
    localparam logic [IW-1:0] LAST = IW'(NUM_PARTITIONS - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_SCAN  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    action_t                act_reg, act_next;
    logic [INDEX_W-1:0]     idx_reg, idx_next;
    logic [SIZE_BITS-1:0]   sz_reg, sz_next;
    logic [PID_W-1:0]       pid_reg, pid_next;
    logic                   bad_reg, bad_next;
    logic [IW-1:0]          addr_reg, addr_next;
    logic [IW-1:0]          chk_reg;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                   m_tuser_reg, m_tuser_next;

    logic                   accept;
    logic                   out_free;
    logic                   rd_en;
    logic [EW-1:0]          rd_data;
    logic                   rd_valid;
    logic                   wr_en;
    logic [EW-1:0]          wr_data;

    logic [SIZE_BITS-1:0]   e_size, e_left;
    logic [PID_W-1:0]       e_owner;
    logic                   e_busy;
    logic                   fits;
    logic [SIZE_BITS-1:0]   remain;

    logic                   done;
    logic                   res_ok;
    logic [INDEX_W-1:0]     res_idx;
    logic [SIZE_BITS-1:0]   rep_size, rep_left;
    logic [PID_W-1:0]       rep_owner;
    logic                   rep_busy;
    logic                   finish;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign e_size  = rd_valid ? rd_data[SIZE_BITS-1:0] : '0;
    assign e_left  = rd_valid ? rd_data[2*SIZE_BITS-1:SIZE_BITS] : '0;
    assign e_owner = rd_valid ? rd_data[2*SIZE_BITS+PID_W-1:2*SIZE_BITS] : '0;
    assign e_busy  = rd_valid ? rd_data[EW-1] : 1'b0;

    ffpa_table #(
        .DEPTH (NUM_PARTITIONS),
        .WIDTH (EW)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_addr  (addr_reg),
        .rd_data  (rd_data),
        .rd_valid (rd_valid),
        .wr_en    (wr_en),
        .wr_addr  (chk_reg),
        .wr_data  (wr_data)
    );

    ffpa_fit #(
        .SIZE_BITS (SIZE_BITS)
    ) u_fit (
        .part_size (e_size),
        .request   (sz_reg),
        .busy      (e_busy),
        .fits      (fits),
        .remain    (remain)
    );

    // evaluate the entry under test
    always_comb begin
        done      = 1'b1;
        res_ok    = 1'b1;
        res_idx   = idx_reg;
        rep_size  = e_size;
        rep_left  = e_left;
        rep_owner = e_owner;
        rep_busy  = e_busy;
        wr_data   = {1'b0, {PID_W{1'b0}}, e_size, e_size};
        if (bad_reg) begin
            res_ok    = 1'b0;
            rep_size  = '0;
            rep_left  = '0;
            rep_owner = '0;
            rep_busy  = 1'b0;
        end else begin
            unique case (act_reg)
                ACT_LOAD: begin
                    wr_data   = {1'b0, {PID_W{1'b0}}, sz_reg, sz_reg};
                    rep_size  = sz_reg;
                    rep_left  = sz_reg;
                    rep_owner = '0;
                    rep_busy  = 1'b0;
                end
                ACT_FREE: begin
                    rep_left  = e_size;
                    rep_owner = '0;
                    rep_busy  = 1'b0;
                end
                ACT_READ: begin
                end
                ACT_ALLOC: begin
                    wr_data   = {1'b1, pid_reg, remain, e_size};
                    res_idx   = INDEX_W'(chk_reg);
                    rep_left  = remain;
                    rep_owner = pid_reg;
                    rep_busy  = 1'b1;
                    if (!fits) begin
                        done      = (chk_reg == LAST);
                        res_ok    = 1'b0;
                        res_idx   = '0;
                        rep_size  = '0;
                        rep_left  = '0;
                        rep_owner = '0;
                        rep_busy  = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign finish = (state_reg == ST_SCAN) && done && out_free;
    assign wr_en  = finish && !bad_reg && (act_reg != ACT_READ) && res_ok;
    assign rd_en  = !((state_reg == ST_SCAN) && done && !out_free);

    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        idx_next      = idx_reg;
        sz_next       = sz_reg;
        pid_next      = pid_reg;
        bad_next      = bad_reg;
        addr_next     = (rd_en && addr_reg != LAST) ? addr_reg + 1'b1 : addr_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    act_next   = action_t'(s_tuser);
                    idx_next   = s_tdata[S_IDX_LSB +: INDEX_W];
                    sz_next    = SIZE_BITS'(s_tdata[S_SIZE_LSB +: VALUE_W]);
                    pid_next   = s_tdata[S_PID_LSB +: PID_W];
                    bad_next   = (action_t'(s_tuser) != ACT_ALLOC) &&
                                 (32'(s_tdata[S_IDX_LSB +: INDEX_W]) >= NUM_PARTITIONS);
                    if ((action_t'(s_tuser) == ACT_ALLOC) ||
                        (32'(s_tdata[S_IDX_LSB +: INDEX_W]) >= NUM_PARTITIONS)) begin
                        addr_next = '0;
                    end else begin
                        addr_next = IW'(s_tdata[S_IDX_LSB +: INDEX_W]);
                    end
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (finish) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_ok;
                    m_tdata_next  = {(M_TDATA_W - M_USED_W)'(0), rep_busy, rep_owner,
                                     VALUE_W'(rep_left), VALUE_W'(rep_size), res_idx};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg     <= act_next;
        idx_reg     <= idx_next;
        sz_reg      <= sz_next;
        pid_reg     <= pid_next;
        bad_reg     <= bad_next;
        addr_reg    <= addr_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        if (rd_en) begin
            chk_reg <= addr_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
